// File: hw/rtl/linear_probe_hash_table_defines.svh
// Assertion macros for the hash table block.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define LPH_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define LPH_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define LPH_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: hw/rtl/lph_pkg.sv
`timescale 1ns / 1ps
package lph_pkg;
  localparam int TABLE_SIZE = 2048;  // power of two: hash and probe wrap by masking
  localparam int KEY_W = 64;
  localparam int LEN_W = 5;
  localparam int MAX_KEY_BYTES = 24;
  localparam int HASH_BASE = 31;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key_word_low;
    logic [KEY_W-1:0] key_word_mid;
    logic [KEY_W-1:0] key_word_high;
    logic [LEN_W-1:0] key_length;
  } lph_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] slot;
  } lph_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_WAIT,
    S_CHECK,
    S_WRITE,
    S_DONE
  } lph_state_t;

  typedef struct packed {
    logic load;       // capture request
    logic hash_step;  // fold one key byte into the hash
    logic start_probe;// index <= home slot, count <= 0
    logic rd;         // latch key and length read at index
    logic advance;    // index++, count++
    logic wr_ins;     // write key and occupy at index
    logic clr;        // clear occupancy at clear pointer
    logic fin_hit;    // result: hit at index
    logic fin_empty;  // result: empty slot at index
    logic fin_full;   // result: wrapped
  } lph_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic occ;
    logic match;
    logic wrapped;
    logic clr_done;
    logic is_search;
  } lph_sts_t;
endpackage

// File: hw/rtl/lph_ram.sv
`timescale 1ns / 1ps
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/lph_datapath.sv
`timescale 1ns / 1ps
`include "linear_probe_hash_table_defines.svh"
module lph_datapath #(
  parameter int KEY_BYTES = 24,
  parameter int HASH_SPAN = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lph_pkg::lph_req_t    req,
  input  lph_pkg::lph_cmd_t    cmd,
  output lph_pkg::lph_sts_t    sts,
  output lph_pkg::lph_rsp_t    rsp
);
  import lph_pkg::*;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = AW + 1;
  localparam int KW = 3 * KEY_W;
  localparam logic [AW-1:0] MASK = AW'(TABLE_SIZE - 1);
  localparam logic [4:0] KB = 5'(KEY_BYTES);
  localparam logic [4:0] HS = 5'(HASH_SPAN);
  localparam logic [AW-1:0] BASE_M = AW'(HASH_BASE % TABLE_SIZE);

  logic [KW-1:0]   key_r, key_nxt;
  logic [LEN_W-1:0] len_r;
  logic            search_r;
  logic [4:0]      bidx_r;
  logic [AW-1:0]   hash_r, pow_r;
  logic [AW-1:0]   idx_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   clr_r;
  logic            clr_done_r;
  logic [LEN_W-1:0] len_sat;
  logic [KW-1:0]   raw_key;
  logic [7:0]      byte_cur;
  logic [AW+7:0]   prod;
  logic [2*AW-1:0] pow_prod;
  logic            occ_q;
  logic [KW-1:0]   kq;
  logic [LEN_W-1:0] lq;
  logic            occ_we;
  logic [AW-1:0]   occ_wa;
  logic [KW-1:0]   rd_key;
  logic [LEN_W-1:0] rd_len;

  // HASH_SPAN is below 32 so both sums stay inside 5 bits plus carry
  always_comb begin
    len_sat = (req.key_length > KB) ? KB : req.key_length;
    raw_key = {req.key_word_high, req.key_word_mid, req.key_word_low};
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      key_nxt[i*8 +: 8] = (5'(i) < len_sat) ? raw_key[i*8 +: 8] : 8'd0;
    end
    byte_cur = key_r[bidx_r*8 +: 8];
    prod = byte_cur * pow_r;
    pow_prod = pow_r * BASE_M;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == MASK) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_nxt;
      len_r <= len_sat;
      search_r <= req.action;
      bidx_r <= (len_sat > HS) ? 5'(len_sat - HS) : 5'd0;
      hash_r <= '0;
      pow_r <= AW'(1);
    end else if (cmd.hash_step) begin
      hash_r <= hash_r + prod[AW-1:0];
      pow_r <= pow_prod[AW-1:0];
      bidx_r <= bidx_r + 5'd1;
    end
    if (cmd.start_probe) begin
      idx_r <= hash_r;
      cnt_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.fin_hit) begin
      rsp.status <= search_r ? ST_FOUND : ST_DUPLICATE;
      rsp.slot <= 11'(idx_r);
    end else if (cmd.fin_empty) begin
      rsp.status <= search_r ? ST_NOT_FOUND : ST_INSERTED;
      rsp.slot <= search_r ? 11'd0 : 11'(idx_r);
    end else if (cmd.fin_full) begin
      rsp.status <= search_r ? ST_NOT_FOUND : ST_FULL;
      rsp.slot <= 11'd0;
    end
  end

  assign occ_we = cmd.clr | cmd.wr_ins;
  assign occ_wa = cmd.clr ? clr_r : idx_r;

  lph_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(cmd.wr_ins),
    .raddr(idx_r), .rdata(occ_q)
  );
  lph_ram #(.WIDTH(KW), .DEPTH(TABLE_SIZE)) u_key (
    .clk(clk), .we(cmd.wr_ins), .waddr(idx_r), .wdata(key_r),
    .raddr(idx_r), .rdata(kq)
  );
  lph_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_SIZE)) u_len (
    .clk(clk), .we(cmd.wr_ins), .waddr(idx_r), .wdata(len_r),
    .raddr(idx_r), .rdata(lq)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= kq;
      rd_len <= lq;
    end
  end

  assign sts.hash_done = (bidx_r >= len_r);
  assign sts.occ = occ_q;
  assign sts.match = (rd_len == len_r) && (rd_key == key_r);
  assign sts.wrapped = (cnt_r == CW'(TABLE_SIZE));
  assign sts.clr_done = clr_done_r;
  assign sts.is_search = search_r;

  `LPH_ASSERT_IMP(a_clr_once, clk, rst_n, clr_done_r, !cmd.clr, "clear after done")
  `LPH_ASSERT_IMP(a_cnt_rng, clk, rst_n, cmd.advance, cnt_r < CW'(TABLE_SIZE), "probe overrun")
  `LPH_ASSERT_IMP(a_fin_1hot, clk, rst_n, 1'b1,
                  $onehot0({cmd.fin_hit, cmd.fin_empty, cmd.fin_full}), "multi finish")
endmodule

// File: hw/rtl/lph_ctrl.sv
`timescale 1ns / 1ps
`include "linear_probe_hash_table_defines.svh"
module lph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lph_pkg::lph_sts_t sts,
  output lph_pkg::lph_cmd_t cmd
);
  import lph_pkg::*;
  localparam logic [1:0] W_HIT = 2'd0, W_EMPTY = 2'd1, W_FULL = 2'd2;
  lph_state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] why_r, why_nxt;
  logic fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r <= 1'b0;
      why_r <= W_FULL;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      why_r <= why_nxt;
    end
  end

  // result register frees the core; only a new finish needs it empty
  // finish cause is latched in S_READ/S_CHECK and resolved in S_DONE
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    ov_nxt = ov_r && !out_ready;
    in_ready = 1'b0;
    why_nxt = why_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.start_probe = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_READ: begin
        if (sts.wrapped) begin
          why_nxt = W_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.occ) begin
          why_nxt = W_EMPTY;
          state_nxt = (sts.is_search) ? S_DONE : S_WRITE;
        end else if (sts.match) begin
          why_nxt = W_HIT;
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_WRITE: begin
        cmd.wr_ins = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          case (why_r)
            W_HIT:   cmd.fin_hit = 1'b1;
            W_EMPTY: cmd.fin_empty = 1'b1;
            default: cmd.fin_full = 1'b1;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign fin = cmd.fin_hit | cmd.fin_empty | cmd.fin_full;
  assign out_valid = ov_r;

  `LPH_ASSERT_IMP(a_busy, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")
  `LPH_ASSERT_NXT(a_load, clk, rst_n, in_valid && in_ready, state_r == S_HASH, "no hash after load")
  `LPH_ASSERT_NXT(a_fin, clk, rst_n, fin, ov_r, "finish without result")
  `LPH_ASSERT_NXT(a_hold, clk, rst_n, ov_r && !out_ready, ov_r, "result dropped")
endmodule

// File: hw/rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Channel  Ports               Payload
// in       in_valid/in_ready   in_data  (lph_req_t: action, key words, length)
// out      out_valid/out_ready out_data (lph_rsp_t: status, slot)
// After reset the occupancy memory is cleared, one slot a cycle; in_ready first
// rises once that clear pass is done.
// A request steps through an accept, one hash step per byte of the last
// min(len,HASH_SPAN) bytes, a probe setup, a read, wait and check per probed
// slot, a write when an insert takes an empty slot, and a finish step.
// The probe walk through the slot memories (registered read) sets the rate.
// A held result does not block a new request; only its finish waits.
module linear_probe_hash_table #(
  parameter int KEY_BYTES = 24,
  parameter int HASH_SPAN = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lph_pkg::lph_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lph_pkg::lph_rsp_t out_data
);
  import lph_pkg::*;
  lph_cmd_t cmd;  // controller -> datapath
  lph_sts_t sts;  // datapath -> controller

  // Controller: clear pass, request accept, hash walk, probe loop, and the
  // result handshake. All finish and write commands come from here.
  lph_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  // Datapath: key capture and masking, hash, probe index, slot memories and
  // the result register that drives out_data.
  lph_datapath #(.KEY_BYTES(KEY_BYTES), .HASH_SPAN(HASH_SPAN)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule

// File: bench/lph_result_checker.sv
`timescale 1ns / 1ps
module lph_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lph_pkg::lph_req_t in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lph_pkg::lph_rsp_t out_data,
  output int                fails,
  output int                pending
);
  import lph_pkg::*;

  localparam int SLOTS = 2048;
  localparam int SPAN  = 20;

  bit               slot_used [SLOTS];
  logic [191:0]     slot_key  [SLOTS];
  logic [LEN_W-1:0] slot_len  [SLOTS];
  lph_rsp_t         due_responses[$];

  // Polynomial hash, base 31, over the last SPAN valid bytes, mod 2048.
  function automatic logic [10:0] home_slot(logic [191:0] k, int unsigned n);
    int unsigned h, p, b, first;
    h = 0;
    p = 1;
    first = (n > SPAN) ? n - SPAN : 0;
    for (b = first; b < n; b++) begin
      h = (h + k[8*b +: 8] * p) & (SLOTS - 1);
      p = (p * HASH_BASE) & (SLOTS - 1);
    end
    return h[10:0];
  endfunction

  function automatic lph_rsp_t lookup_outcome(lph_req_t r);
    int unsigned  n, idx, steps;
    logic [191:0] k, m;
    bit           done;
    lph_rsp_t     rsp;
    n = (r.key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.key_length;
    m = (n >= MAX_KEY_BYTES) ? {192{1'b1}} : ((192'd1 << (8 * n)) - 192'd1);
    k = {r.key_word_high, r.key_word_mid, r.key_word_low} & m;
    idx = home_slot(k, n);
    rsp.status = (r.action == ACT_SEARCH) ? ST_NOT_FOUND : ST_FULL;
    rsp.slot = '0;
    done = 1'b0;
    for (steps = 0; steps < SLOTS && !done; steps++) begin
      if (!slot_used[idx]) begin
        if (r.action == ACT_INSERT) begin
          slot_used[idx] = 1'b1;
          slot_key[idx] = k;
          slot_len[idx] = LEN_W'(n);
          rsp.status = ST_INSERTED;
          rsp.slot = 11'(idx);
        end
        done = 1'b1;
      end else if (slot_len[idx] == n && slot_key[idx] == k) begin
        rsp.status = (r.action == ACT_SEARCH) ? ST_FOUND : ST_DUPLICATE;
        rsp.slot = 11'(idx);
        done = 1'b1;
      end else begin
        idx = (idx + 1) & (SLOTS - 1);
      end
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    lph_rsp_t want;
    if (rst_n) begin
      if (in_valid && in_ready) due_responses = {due_responses, lookup_outcome(in_data)};
      if (out_valid && out_ready) begin
        if (due_responses.size() == 0) begin
          $error("unexpected result: status %0d slot %0d", out_data.status, out_data.slot);
          fails++;
        end else begin
          want = due_responses.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot: expected %0d actual %0d", want.slot, out_data.slot);
            fails++;
          end
        end
      end
      pending = due_responses.size();
    end
  end
endmodule

// File: bench/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
  import lph_pkg::*;

  localparam int SLOTS     = 2048;
  localparam int LIMIT     = 4_000_000;  // cycles; full-wrap walks dominate
  localparam int IDLE_PCT  = 38;
  localparam int CALM_LO   = 40_000;     // window with no idling on either side
  localparam int CALM_HI   = 60_000;
  localparam int HOLD_LO   = 3_000;      // long sink hold-off, after the clear pass
  localparam int HOLD_HI   = 3_400;
  localparam int RAND_REQS = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lph_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lph_rsp_t out_data;
  int       fails, pending;
  int       cyc = 0;

  // Stimulus bookkeeping: keys offered for insert, and home slots already targeted.
  lph_req_t known_keys[$];
  bit       claimed[SLOTS];
  int       n_insert = 0, n_search = 0;

  always #5 clk = ~clk;
  always @(posedge clk) cyc <= cyc + 1;

  linear_probe_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  lph_result_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fails(fails), .pending(pending)
  );

  function automatic bit calm();
    return cyc >= CALM_LO && cyc < CALM_HI;
  endfunction

  function automatic int eff_len(lph_req_t r);
    return (r.key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.key_length;
  endfunction

  function automatic lph_req_t mk(action_t a, logic [63:0] lo, logic [63:0] mi,
                                  logic [63:0] hi, int n);
    lph_req_t r;
    r.action = a;
    r.key_word_low = lo;
    r.key_word_mid = mi;
    r.key_word_high = hi;
    r.key_length = LEN_W'(n);
    return r;
  endfunction

  // Random key, all 64 bits of each word live; lengths cover 0..31 so the
  // saturating lengths above 24 show up too.
  function automatic lph_req_t rand_key(action_t a);
    return mk(a, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              $urandom_range(31));
  endfunction

  function automatic logic [10:0] home_of(lph_req_t r);
    return u_chk.home_slot({r.key_word_high, r.key_word_mid, r.key_word_low}, eff_len(r));
  endfunction

  // Build a key (length >= 2) whose home slot is s. The last two hashed bytes
  // x, y add P*(x + 31*y); 31 is odd so P has an inverse mod 2048.
  function automatic lph_req_t key_for_slot(int s);
    lph_req_t     r;
    logic [191:0] k;
    int           n, first, p, inv, h0, t, x, y, i;
    r = mk(ACT_INSERT, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
           $urandom_range(31, 2));
    n = eff_len(r);
    k = {r.key_word_high, r.key_word_mid, r.key_word_low};
    k[8*(n-2) +: 16] = '0;
    h0 = u_chk.home_slot(k, n);
    first = (n > 20) ? n - 20 : 0;
    p = 1;
    for (i = first; i < n - 2; i++) p = (p * 31) & (SLOTS - 1);
    inv = p;
    repeat (3) inv = (inv * (2 - p * inv)) & (SLOTS - 1);
    t = ((s - h0) * inv) & (SLOTS - 1);
    x = 0;
    for (y = 255; y >= 0; y--)
      if (((t - 31 * y) & (SLOTS - 1)) < 256) begin
        x = (t - 31 * y) & (SLOTS - 1);
        k[8*(n-2) +: 16] = {y[7:0], x[7:0]};
      end
    {r.key_word_high, r.key_word_mid, r.key_word_low} = k;
    return r;
  endfunction

  // Offer one request at a falling edge; hold it until taken, then maybe idle.
  task automatic offer(input lph_req_t r);
    in_data <= r;
    in_valid <= 1'b1;
    if (r.action == ACT_INSERT) begin
      n_insert++;
      known_keys = {known_keys, r};
      claimed[home_of(r)] = 1'b1;
    end else begin
      n_search++;
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    while (!calm() && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic search_known();
    lph_req_t r;
    r = known_keys[$urandom_range(known_keys.size() - 1)];
    r.action = ACT_SEARCH;
    offer(r);
  endtask

  // Receiver: random stalls, a calm window, and one long hold-off so the
  // block backs up and drops in_ready while requests keep coming.
  initial begin
    forever begin
      @(negedge clk);
      if (cyc >= HOLD_LO && cyc < HOLD_HI) out_ready <= 1'b0;
      else if (calm()) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (cyc >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int       free_slots[$];
    int       i, j, tmp, pick;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty key, collisions at home 0, length corners, masking.
    offer(mk(ACT_SEARCH, '0, '0, '0, 0));                       // empty table
    offer(mk(ACT_INSERT, '1, '1, '1, 0));                       // empty key, bytes ignored
    offer(mk(ACT_SEARCH, '0, '0, '0, 0));
    offer(mk(ACT_INSERT, 64'h55, '0, '0, 0));                   // duplicate of empty key
    offer(mk(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, 1));  // one zero byte, home 0
    offer(mk(ACT_INSERT, '0, '1, '1, 2));                       // two zero bytes, home 0
    offer(mk(ACT_SEARCH, 64'hAB00, '0, '0, 1));                 // found past home
    offer(mk(ACT_SEARCH, '0, '0, '0, 3));                       // same bytes, longer: miss
    offer(mk(ACT_INSERT, '1, '1, '1, 24));
    offer(mk(ACT_INSERT, '1, '1, '1, 31));                      // saturates: duplicate
    offer(mk(ACT_SEARCH, '1, '1, '1, 25));
    offer(mk(ACT_INSERT, '1, '1, '0, 16));
    offer(mk(ACT_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
             64'h0F0F_F0F0, 20));
    offer(mk(ACT_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
             64'h0F0F_F0F0, 21));                                // first byte leaves the span
    offer(mk(ACT_SEARCH, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
             64'hFF0F_0F_F0F0, 20));
    offer(mk(ACT_INSERT, 64'hFF, '0, '0, 1));
    offer(mk(ACT_SEARCH, 64'h77FF, '1, '1, 1));                 // high bytes masked
    offer(mk(ACT_SEARCH, '1, '1, '1, 23));                      // absent

    // Random mix at light load: collisions, duplicates, hits and misses.
    for (i = 0; i < RAND_REQS; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) offer(rand_key(ACT_INSERT));
      else if (pick < 70) search_known();
      else if (pick < 80) offer(known_keys[$urandom_range(known_keys.size() - 1)]);
      else offer(rand_key(ACT_SEARCH));
    end

    // Fill: one crafted insert per untargeted slot, in shuffled order, with
    // some hits mixed in. Collisions above push the table to full.
    for (i = 0; i < SLOTS; i++) if (!claimed[i]) free_slots = {free_slots, i};
    for (i = free_slots.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = free_slots[i];
      free_slots[i] = free_slots[j];
      free_slots[j] = tmp;
    end
    foreach (free_slots[i]) begin
      if ($urandom_range(39) == 0) search_known();
      offer(key_for_slot(free_slots[i]));
    end

    // Full table: new inserts wrap, absent searches wrap, stored keys still hit.
    repeat (6) offer(rand_key(ACT_INSERT));
    repeat (4) offer(rand_key(ACT_SEARCH));
    repeat (6) search_known();
    repeat (2) offer(known_keys[$urandom_range(known_keys.size() - 1)]);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests (%0d inserts, %0d searches): collisions, duplicates,",
             n_insert + n_search, n_insert, n_search);
    $display("masked and saturated lengths, output backpressure, and a full-table wrap.");
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lph_pkg.sv
hw/rtl/lph_ram.sv
hw/rtl/lph_datapath.sv
hw/rtl/lph_ctrl.sv
hw/rtl/linear_probe_hash_table.sv
bench/lph_result_checker.sv
bench/tb_linear_probe_hash_table.sv
